[src/closing_threat_detector_core_assert.svh]
// Assertion macros for the closing threat detector core.
// Used by the top level; expects clk and rst in scope.
`ifndef CLOSING_THREAT_DETECTOR_CORE_ASSERT_SVH
`define CLOSING_THREAT_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication
`define CTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctd assertion failed");

// Next-cycle implication
`define CTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctd assertion failed");

`endif

[src/ctd_pkg.sv]
// Shared types and constants for the closing threat detector.
// No dependencies.
package ctd_pkg;

  // Register indexes on the config port
  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_SPEED_THR  = 2'd2;

  localparam int unsigned PADDR_W = 4;

  // Serial multiplier and square root widths
  localparam int unsigned MUL_W  = 35;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned RAD_W  = 68;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned SEQ_CNT_W = 6;

  // Divider: numerator |rd| * v fits in 58 bits
  localparam int unsigned NUM_W = 58;

  localparam logic [31:0] EVENT_GAP_MS = 32'd5000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VM_GO, ST_VM_W, ST_VQ_GO, ST_VQ_W,
    ST_DM_GO, ST_DM_W, ST_DQ_GO, ST_DQ_W,
    ST_QM_GO, ST_QM_W, ST_DV, ST_DF, ST_SM_GO, ST_SM_W,
    ST_SQ_GO, ST_SQ_W,
    ST_C1_GO, ST_C1_W, ST_C2_GO, ST_C2_W, ST_CQ_GO, ST_CQ_W,
    ST_FIN
  } ctd_state_t;

endpackage

[src/closing_threat_detector_core.sv]
// Sequencing: an owner transaction goes straight to the result; an object transaction
// runs fourteen serial products, four square roots and three divides (each with its
// fold step); fewer when a speed or range test fails early.
// Throughput: one transaction at a time; next accepted after the result is loaded.
// Reset: synchronous, active high; registers back to 100 / 5000 / 1000, owner
// state, count and event time cleared. Threat id slots hold no reset value.
module closing_threat_detector_core #(
  parameter int unsigned THREAT_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          req_type,
  input  logic [15:0]                   object_id,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  input  logic signed [31:0]            pos_z,
  input  logic signed [23:0]            vel_x,
  input  logic signed [23:0]            vel_y,
  input  logic signed [23:0]            vel_z,
  input  logic [31:0]                   now_ms,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          is_threat,
  output logic                          recorded,
  output logic [4:0]                    threat_total,
  output logic                          event_raised,
  output logic [31:0]                   event_stamp
);
  import ctd_pkg::*;

  localparam int unsigned CNT_W = $clog2(THREAT_SLOTS + 1);
  localparam int unsigned IDX_W = (THREAT_SLOTS > 1) ? $clog2(THREAT_SLOTS) : 1;

  ctd_state_t state, state_next;

  // config registers
  logic [22:0] range_low, range_high;
  logic [14:0] speed_threshold;
  logic        cfg_wr;

  // owner state
  logic signed [31:0] own_pos [3];
  logic signed [23:0] own_vel [3];
  logic [31:0]        tick_time;
  logic [31:0]        last_event_time;
  logic [CNT_W-1:0]   threat_count;
  logic [15:0]        threat_ids [THREAT_SLOTS];

  // per-transaction working registers
  logic [15:0]        obj_id;
  logic               owner;
  logic signed [24:0] rv [3];
  logic signed [32:0] rd [3];
  logic [1:0]         k;
  logic [RAD_W-1:0]   acc;
  logic [24:0]        v;
  logic [33:0]        d;
  logic [26:0]        s;
  logic [25:0]        dm;
  logic [NUM_W-1:0]   num;
  logic [33:0]        drem;
  logic [24:0]        quot;
  logic [SEQ_CNT_W-1:0] cnt;
  logic               ok;

  // shared units
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  ctd_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_prod)
  );

  ctd_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc),
    .done(sq_done), .root(sq_root)
  );

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_LOW:  prdata = {9'd0, range_low};
      REG_RANGE_HIGH: prdata = {9'd0, range_high};
      REG_SPEED_THR:  prdata = {17'd0, speed_threshold};
      default:        prdata = '0;
    endcase
  end

  // magnitudes of the selected components
  logic [24:0] rv_mag;
  logic [32:0] rd_mag;
  assign rv_mag = rv[k][24] ? 25'(-rv[k]) : 25'(rv[k]);
  assign rd_mag = rd[k][32] ? 33'(-rd[k]) : 33'(rd[k]);

  // divider step
  logic [34:0] dv_trial;
  logic        dv_ge;
  assign dv_trial = {drem, num[NUM_W-1]};
  assign dv_ge    = dv_trial >= {1'b0, d};

  // scaled direction minus relative velocity
  logic signed [26:0] sd, diff;
  assign sd   = rd[k][32] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign diff = sd - 27'(rv[k]);

  // test conditions
  logic d_fail, s_fail, c_ok;
  assign d_fail = (sq_root == '0) || (sq_root < {3'd0, range_low, 8'd0}) ||
                  (sq_root > {3'd0, range_high, 8'd0});
  assign s_fail = ({1'b0, s} * 38'd1000) > ({13'd0, v} * 38'd1414);
  assign c_ok   = sq_root >= {11'd0, speed_threshold, 8'd0};

  // finish: record and event
  logic fin_go, rec, raise;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+4:0] total_ext;
  assign fin_go = (state == ST_FIN) && (!result_valid || !result_stall);
  assign rec    = ok && (threat_count < CNT_W'(THREAT_SLOTS));
  assign raise  = rec && (tick_time > last_event_time) &&
                  (tick_time - last_event_time > EVENT_GAP_MS);
  assign count_next = rec ? threat_count + 1'b1 : threat_count;
  assign total_ext  = {5'd0, count_next};

  assign item_stall = (state != ST_IDLE);

  // sequencer: next state and unit starts
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE:  if (item_valid) state_next = req_type ? ST_VM_GO : ST_FIN;
      ST_VM_GO: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(rv_mag);
        mul_b = MUL_W'(rv_mag);
        state_next = ST_VM_W;
      end
      ST_VM_W:  if (mul_done) state_next = (k == 2'd2) ? ST_VQ_GO : ST_VM_GO;
      ST_VQ_GO: begin
        sq_start = 1'b1;
        state_next = ST_VQ_W;
      end
      ST_VQ_W:  if (sq_done) state_next = (sq_root == '0) ? ST_FIN : ST_DM_GO;
      ST_DM_GO: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(rd_mag);
        mul_b = MUL_W'(rd_mag);
        state_next = ST_DM_W;
      end
      ST_DM_W:  if (mul_done) state_next = (k == 2'd2) ? ST_DQ_GO : ST_DM_GO;
      ST_DQ_GO: begin
        sq_start = 1'b1;
        state_next = ST_DQ_W;
      end
      ST_DQ_W:  if (sq_done) state_next = d_fail ? ST_FIN : ST_QM_GO;
      ST_QM_GO: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(rd_mag);
        mul_b = MUL_W'(v);
        state_next = ST_QM_W;
      end
      ST_QM_W:  if (mul_done) state_next = ST_DV;
      ST_DV:    if (cnt == SEQ_CNT_W'(NUM_W - 1)) state_next = ST_DF;
      ST_DF:    state_next = ST_SM_GO;
      ST_SM_GO: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(dm);
        mul_b = MUL_W'(dm);
        state_next = ST_SM_W;
      end
      ST_SM_W:  if (mul_done) state_next = (k == 2'd2) ? ST_SQ_GO : ST_QM_GO;
      ST_SQ_GO: begin
        sq_start = 1'b1;
        state_next = ST_SQ_W;
      end
      ST_SQ_W:  if (sq_done) state_next = ST_C1_GO;
      ST_C1_GO: begin
        if (s_fail) begin
          state_next = ST_FIN;
        end else begin
          mul_start = 1'b1;
          mul_a = MUL_W'(v);
          mul_b = MUL_W'(v);
          state_next = ST_C1_W;
        end
      end
      ST_C1_W:  if (mul_done) state_next = ST_C2_GO;
      ST_C2_GO: begin
        mul_start = 1'b1;
        mul_a = MUL_W'(s);
        mul_b = MUL_W'(s);
        state_next = ST_C2_W;
      end
      ST_C2_W:  if (mul_done) state_next = ST_CQ_GO;
      ST_CQ_GO: begin
        sq_start = 1'b1;
        state_next = ST_CQ_W;
      end
      ST_CQ_W:  if (sq_done) state_next = ST_FIN;
      ST_FIN:   if (fin_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control state, config and owner state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      range_low       <= 23'd100;
      range_high      <= 23'd5000;
      speed_threshold <= 15'd1000;
      own_pos         <= '{default: '0};
      own_vel         <= '{default: '0};
      tick_time       <= '0;
      last_event_time <= '0;
      threat_count    <= '0;
      result_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_RANGE_LOW:  range_low <= pwdata[22:0];
          REG_RANGE_HIGH: range_high <= pwdata[22:0];
          REG_SPEED_THR:  speed_threshold <= pwdata[14:0];
          default: ;
        endcase
      end
      // owner transaction starts a tick
      if (state == ST_IDLE && item_valid && !req_type) begin
        own_pos      <= '{pos_x, pos_y, pos_z};
        own_vel      <= '{vel_x, vel_y, vel_z};
        tick_time    <= now_ms;
        threat_count <= '0;
      end
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (fin_go) begin
        result_valid <= 1'b1;
        threat_count <= count_next;
        if (raise) last_event_time <= tick_time;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        obj_id <= object_id;
        owner  <= !req_type;
        rv[0]  <= 25'(vel_x) - 25'(own_vel[0]);
        rv[1]  <= 25'(vel_y) - 25'(own_vel[1]);
        rv[2]  <= 25'(vel_z) - 25'(own_vel[2]);
        rd[0]  <= 33'(own_pos[0]) - 33'(pos_x);
        rd[1]  <= 33'(own_pos[1]) - 33'(pos_y);
        rd[2]  <= 33'(own_pos[2]) - 33'(pos_z);
        acc    <= '0;
        k      <= '0;
        ok     <= 1'b0;
      end
      ST_VM_W, ST_DM_W: if (mul_done) begin
        acc <= acc + mul_prod[RAD_W-1:0];
        k   <= (k == 2'd2) ? 2'd0 : k + 1'b1;
      end
      ST_VQ_W: if (sq_done) begin
        v   <= sq_root[24:0];
        acc <= '0;
      end
      ST_DQ_W: if (sq_done) begin
        d   <= sq_root;
        acc <= '0;
      end
      ST_QM_W: if (mul_done) begin
        num  <= mul_prod[NUM_W-1:0];
        drem <= '0;
        cnt  <= '0;
      end
      ST_DV: begin
        num  <= {num[NUM_W-2:0], 1'b0};
        drem <= dv_ge ? 34'(dv_trial - {1'b0, d}) : dv_trial[33:0];
        quot <= {quot[23:0], dv_ge};
        cnt  <= cnt + 1'b1;
      end
      ST_DF: dm <= diff[26] ? 26'(-diff) : 26'(diff);
      ST_SM_W: if (mul_done) begin
        acc <= acc + mul_prod[RAD_W-1:0];
        k   <= (k == 2'd2) ? 2'd0 : k + 1'b1;
      end
      ST_SQ_W: if (sq_done) s <= sq_root[26:0];
      ST_C1_W: if (mul_done) acc <= {mul_prod[RAD_W-3:0], 2'b00};
      ST_C2_W: if (mul_done) acc <= (acc - mul_prod[RAD_W-1:0]) >> 2;
      ST_CQ_W: if (sq_done) ok <= c_ok;
      default: ;
    endcase
  end

  // result register and id slots
  always_ff @(posedge clk) begin
    if (fin_go) begin
      is_threat    <= ok && !owner;
      recorded     <= rec && !owner;
      threat_total <= total_ext[4:0];
      event_raised <= raise && !owner;
      event_stamp  <= (raise && !owner) ? tick_time : last_event_time;
      if (rec && !owner) threat_ids[threat_count[IDX_W-1:0]] <= obj_id;
    end
  end

`include "closing_threat_detector_core_assert.svh"

  `CTD_ASSERT_NOW(a_rec_threat, result_valid && recorded, is_threat)
  `CTD_ASSERT_NOW(a_event_rec, result_valid && event_raised, recorded)
  `CTD_ASSERT_NEXT(a_busy_after, item_valid && !item_stall, item_stall)
  `CTD_ASSERT_NOW(a_cnt_max, 1'b1, threat_count <= CNT_W'(THREAT_SLOTS))

endmodule

[src/ctd_mul.sv]
// Bit-serial unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on ctd_pkg.
module ctd_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ctd_pkg::MUL_W-1:0]   a,
  input  logic [ctd_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [ctd_pkg::PROD_W-1:0]  product
);
  import ctd_pkg::*;

  logic                 busy;
  logic [MUL_W-1:0]     mcand;
  logic [MUL_W-1:0]     mplr;
  logic [SEQ_CNT_W-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SEQ_CNT_W'(MUL_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= a;
      mplr    <= b;
      product <= '0;
      cnt     <= '0;
    end else if (busy) begin
      product <= {product[PROD_W-2:0], 1'b0} +
                 (mplr[MUL_W-1] ? {{MUL_W{1'b0}}, mcand} : {PROD_W{1'b0}});
      mplr    <= {mplr[MUL_W-2:0], 1'b0};
      cnt     <= cnt + 1'b1;
    end
  end

endmodule

[src/ctd_isqrt.sv]
// Restoring integer square root, two radicand bits per cycle, truncated.
// Depends on ctd_pkg.
module ctd_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ctd_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [ctd_pkg::ROOT_W-1:0]  root
);
  import ctd_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 4;

  logic                 busy;
  logic [RAD_W-1:0]     rad;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     rem_sh;
  logic [REM_W-1:0]     trial;
  logic                 fits;
  logic [SEQ_CNT_W-1:0] cnt;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SEQ_CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one root bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for closing_threat_detector_core: random and directed
// owner/object transactions, an in-bench threat predictor, APB register phases.
// Depends on ctd_pkg and the closing_threat_detector_core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctd_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam logic REQ_OWNER = 1'b0;
  localparam logic REQ_OBJECT = 1'b1;

  typedef struct {
    logic              req;
    logic [15:0]       id;
    logic signed [31:0] px, py, pz;
    logic signed [23:0] vx, vy, vz;
    logic [31:0]       now;
  } track_t;

  typedef struct {
    logic        threat;
    logic        rec;
    logic [4:0]  total;
    logic        raised;
    logic [31:0] stamp;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic req_type = 1'b0;
  logic [15:0] object_id = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [23:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [31:0] now_ms = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic is_threat, recorded, event_raised;
  logic [4:0] threat_total;
  logic [31:0] event_stamp;

  closing_threat_detector_core #(.THREAT_SLOTS(SLOTS)) dut (.*);

  always #5 clk = ~clk;

  // Predictor state and register copies
  longint unsigned cfg_range_lo = 100, cfg_range_hi = 5000, cfg_speed_min = 1000;
  longint own_pos[3], own_vel[3];
  logic [31:0] tick_ms, last_event_ms;
  int unsigned threat_cnt;

  track_t   pending_tracks[$];
  verdict_t expected_verdicts[$];
  int unsigned errors = 0;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  bit calm;

  // Generator-side copy of the owner, used to build closing objects
  logic signed [31:0] gen_pos[3];
  logic signed [23:0] gen_vel[3];
  logic [31:0] gen_clock;

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint unsigned floor_root(logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r[63:0];
  endfunction

  function automatic verdict_t predict_threat(track_t t);
    verdict_t o;
    longint p[3], vl[3], rv[3], rd[3], sd;
    longint unsigned m, sq, vs, v, d, q, ss, s, c;
    logic [127:0] dsum;
    bit ok;
    p[0] = t.px; p[1] = t.py; p[2] = t.pz;
    vl[0] = t.vx; vl[1] = t.vy; vl[2] = t.vz;
    o = '{1'b0, 1'b0, 5'd0, 1'b0, 32'd0};
    if (t.req == REQ_OWNER) begin
      for (int k = 0; k < 3; k++) begin
        own_pos[k] = p[k];
        own_vel[k] = vl[k];
      end
      tick_ms = t.now;
      threat_cnt = 0;
    end else begin
      vs = 0;
      for (int k = 0; k < 3; k++) begin
        rv[k] = vl[k] - own_vel[k];
        m = magnitude(rv[k]);
        vs += m * m;
      end
      v = floor_root({64'd0, vs});
      ok = (v != 0);
      d = 0;
      if (ok) begin
        dsum = '0;
        for (int k = 0; k < 3; k++) begin
          rd[k] = own_pos[k] - p[k];
          m = magnitude(rd[k]);
          sq = m * m;
          dsum += {64'd0, sq};
        end
        d = floor_root(dsum);
        if (d == 0) ok = 0;
      end
      if (ok && (d < (cfg_range_lo << 8) || d > (cfg_range_hi << 8))) ok = 0;
      if (ok) begin
        ss = 0;
        for (int k = 0; k < 3; k++) begin
          q = magnitude(rd[k]) * v / d;
          sd = rd[k] < 0 ? longint'(0) - longint'(q) : longint'(q);
          m = magnitude(sd - rv[k]);
          ss += m * m;
        end
        s = floor_root({64'd0, ss});
        if (s * 1000 > v * 1414) begin
          ok = 0;
        end else begin
          c = floor_root({64'd0, (4 * v * v - s * s) >> 2});
          if (c < (cfg_speed_min << 8)) ok = 0;
        end
      end
      if (ok) begin
        o.threat = 1'b1;
        if (threat_cnt < SLOTS) begin
          threat_cnt++;
          o.rec = 1'b1;
          // rate limit: forward time only, strictly more than the gap
          if (tick_ms > last_event_ms && tick_ms - last_event_ms > EVENT_GAP_MS) begin
            last_event_ms = tick_ms;
            o.raised = 1'b1;
          end
        end
      end
    end
    o.total = threat_cnt[4:0];
    o.stamp = last_event_ms;
    return o;
  endfunction

  // Input driver: one transaction held until accepted
  always @(posedge clk) begin
    track_t nx;
    cycles <= cycles + 1;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) begin
        expected_verdicts.push_back(predict_threat('{req_type, object_id, pos_x, pos_y,
          pos_z, vel_x, vel_y, vel_z, now_ms}));
        accepted <= accepted + 1;
      end
      if (pending_tracks.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        nx = pending_tracks.pop_front();
        item_valid <= 1'b1;
        req_type <= nx.req;
        object_id <= nx.id;
        pos_x <= nx.px; pos_y <= nx.py; pos_z <= nx.pz;
        vel_x <= nx.vx; vel_y <= nx.vy; vel_z <= nx.vz;
        now_ms <= nx.now;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %0h want %0h", accepted, what, got, want);
    errors++;
  endtask

  // Result monitor and stall generator
  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected transaction", 32'd0, 32'd0);
        end else begin
          w = expected_verdicts.pop_front();
          if (is_threat !== w.threat) report_mismatch("is_threat", is_threat, w.threat);
          if (recorded !== w.rec) report_mismatch("recorded", recorded, w.rec);
          if (threat_total !== w.total) report_mismatch("threat_total", threat_total, w.total);
          if (event_raised !== w.raised) report_mismatch("event_raised", event_raised, w.raised);
          if (event_stamp !== w.stamp) report_mismatch("event_stamp", event_stamp, w.stamp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("closing_threat_detector_core: mismatch");
      $finish;
    end
  end

  // Quiet stretch: no idling on either side
  assign calm = (accepted >= 200 && accepted < 300);

  task automatic add_owner(logic [31:0] when);
    track_t t;
    for (int k = 0; k < 3; k++) begin
      gen_pos[k] = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
      gen_vel[k] = $signed(24'($urandom_range(0, 32'h3fffff))) - 24'sh200000;
    end
    t = '{REQ_OWNER, 16'($urandom), gen_pos[0], gen_pos[1], gen_pos[2],
          gen_vel[0], gen_vel[1], gen_vel[2], when};
    pending_tracks.push_back(t);
  endtask

  // Object on a closing course, or pure noise
  task automatic add_object(bit shaped);
    track_t t;
    logic signed [31:0] off[3], p[3];
    logic signed [23:0] vv[3];
    int sh;
    sh = $urandom_range(0, 4);
    for (int k = 0; k < 3; k++) begin
      off[k] = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
      p[k] = gen_pos[k] + off[k];
      vv[k] = gen_vel[k] - 24'(off[k] >>> sh) + 24'($signed($urandom_range(0, 512)) - 256);
    end
    if (shaped)
      t = '{REQ_OBJECT, 16'($urandom), p[0], p[1], p[2], vv[0], vv[1], vv[2], $urandom};
    else
      t = '{REQ_OBJECT, 16'($urandom), $urandom, $urandom, $urandom,
            24'($urandom), 24'($urandom), 24'($urandom), $urandom};
    pending_tracks.push_back(t);
  endtask

  task automatic drain;
    do @(negedge clk);
    while (pending_tracks.size() > 0 || item_valid || expected_verdicts.size() > 0);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RANGE_LOW:  cfg_range_lo = val & 32'h7fffff;
      REG_RANGE_HIGH: cfg_range_hi = val & 32'h7fffff;
      REG_SPEED_THR:  cfg_speed_min = val & 32'h7fff;
      default: ;
    endcase
  endtask

  task automatic random_ticks(int unsigned n);
    int unsigned made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) gen_clock = $urandom;        // jump, maybe backwards
      else gen_clock = gen_clock + $urandom_range(0, 8000);
      add_owner(gen_clock);
      made++;
      repeat ($urandom_range(0, 20)) begin
        add_object($urandom_range(99) < 85);
        made++;
      end
    end
  endtask

  initial begin
    track_t t;
    for (int k = 0; k < 3; k++) begin
      own_pos[k] = 0; own_vel[k] = 0; gen_pos[k] = '0; gen_vel[k] = '0;
    end
    tick_ms = '0; last_event_ms = '0; threat_cnt = 0; gen_clock = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: objects against the reset owner, zero speed, zero distance,
    // field extremes, event gap and backwards time
    add_object(1'b1);
    add_object(1'b1);
    t = '{REQ_OBJECT, 16'h0000, 32'sd0, 32'sd0, 32'sd0, 24'sd0, 24'sd0, 24'sd0, 32'd0};
    pending_tracks.push_back(t);
    t = '{REQ_OWNER, 16'hffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          -24'sh800000, -24'sh800000, -24'sh800000, 32'hffffffff};
    pending_tracks.push_back(t);
    t = '{REQ_OBJECT, 16'hffff, -32'sh80000000, -32'sh80000000, -32'sh80000000,
          24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 32'hffffffff};
    pending_tracks.push_back(t);
    t = '{REQ_OBJECT, 16'h1234, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          24'sh000100, 24'sd0, 24'sd0, 32'd0};
    pending_tracks.push_back(t);
    add_owner(32'd6000);
    repeat (5) add_object(1'b1);
    add_owner(32'd3000);
    repeat (4) add_object(1'b1);
    add_owner(32'd20000);
    repeat (5) add_object(1'b1);
    gen_clock = 32'd20000;
    drain();

    // Widest window, no speed floor: slots fill up
    write_reg(REG_RANGE_LOW, 32'd0);
    write_reg(REG_RANGE_HIGH, 32'h7fffff);
    write_reg(REG_SPEED_THR, 32'd0);
    random_ticks(130);
    drain();

    write_reg(REG_RANGE_LOW, 32'd50);
    write_reg(REG_RANGE_HIGH, 32'd3000);
    write_reg(REG_SPEED_THR, 32'd200);
    random_ticks(130);
    drain();

    // Inverted window and top speed floor: nothing qualifies
    write_reg(REG_RANGE_LOW, 32'hffffffff);
    write_reg(REG_RANGE_HIGH, 32'd0);
    write_reg(REG_SPEED_THR, 32'hffffffff);
    random_ticks(40);
    drain();

    write_reg(REG_RANGE_LOW, 32'd100);
    write_reg(REG_RANGE_HIGH, 32'd5000);
    write_reg(REG_SPEED_THR, 32'd700);
    random_ticks(180);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("closing_threat_detector_core: match");
    else
      $display("closing_threat_detector_core: mismatch");
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/ctd_pkg.sv
src/ctd_mul.sv
src/ctd_isqrt.sv
src/closing_threat_detector_core.sv
dv/testbench.sv
